[rtl/core/gsm7_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gsm7_pkg;

  localparam logic [6:0] ESC_SEPTET  = 7'h1B;
  localparam logic [6:0] CR_SEPTET   = 7'h0D;
  localparam logic [6:0] EURO_SEPTET = 7'h65;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] packed_octet;
    logic       message_start;
    logic       final_octet;
  } in_word_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       run_last;
    logic       text_complete;
  } out_word_t;

  // Septets taken from one octet; the first is always present in a record.
  typedef struct packed {
    logic [6:0] sa;
    logic       a_esc;
    logic       a_done;
    logic       b_valid;
    logic [6:0] sb;
    logic       b_esc;
    logic       b_done;
  } septet_rec_t;

  typedef struct packed {
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } utf8_seq_t;

  // UTF-8 of each default-alphabet septet, first byte in the low half.
  localparam logic [15:0] BASIC_MAP [0:127] = '{
    16'h0040, 16'ha3c2, 16'h0024, 16'ha5c2, 16'ha8c3, 16'ha9c3, 16'hb9c3, 16'hacc3,
    16'hb2c3, 16'h87c3, 16'h000A, 16'h98c3, 16'hb8c3, 16'h000D, 16'h85c3, 16'ha5c3,
    16'h94ce, 16'h005F, 16'ha6ce, 16'h93ce, 16'h9bce, 16'ha9ce, 16'ha0ce, 16'ha8ce,
    16'ha3ce, 16'h98ce, 16'h9ece, 16'h001B, 16'h86c3, 16'ha6c3, 16'hb2ce, 16'h89c3,
    16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'ha4c2, 16'h0025, 16'h0026, 16'h0027,
    16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
    16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
    16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
    16'ha1c2, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
    16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
    16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
    16'h0058, 16'h0059, 16'h005A, 16'h84c3, 16'h96c3, 16'h91c3, 16'h9cc3, 16'ha7c2,
    16'hbfc2, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
    16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
    16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
    16'h0078, 16'h0079, 16'h007A, 16'ha4c3, 16'hb6c3, 16'hb1c3, 16'hbcc3, 16'ha0c3
  };

  function automatic utf8_seq_t map_septet(input logic [6:0] s, input logic escaped);
    utf8_seq_t r;
    r = '0;
    if (escaped) begin
      case (s)
        EURO_SEPTET: begin
          r.n  = 2'd3;
          r.b0 = 8'hE2;
          r.b1 = 8'h82;
          r.b2 = 8'hAC;
        end
        7'h14: begin r.n = 2'd1; r.b0 = 8'h5E; end
        7'h28: begin r.n = 2'd1; r.b0 = 8'h7B; end
        7'h29: begin r.n = 2'd1; r.b0 = 8'h7D; end
        7'h2F: begin r.n = 2'd1; r.b0 = 8'h5C; end
        7'h3C: begin r.n = 2'd1; r.b0 = 8'h5B; end
        7'h3D: begin r.n = 2'd1; r.b0 = 8'h7E; end
        7'h3E: begin r.n = 2'd1; r.b0 = 8'h5D; end
        7'h40: begin r.n = 2'd1; r.b0 = 8'h7C; end
        default: r.n = 2'd0;
      endcase
    end else if (s != ESC_SEPTET) begin
      r.b0 = BASIC_MAP[s][7:0];
      r.b1 = BASIC_MAP[s][15:8];
      r.n  = (r.b1 != 8'h00) ? 2'd2 : 2'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/gsm7_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module gsm7_front (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  gsm7_pkg::in_word_t     in_data,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire  [7:0]             cfg_data,
  output logic                   push,
  output gsm7_pkg::septet_rec_t  push_data,
  input  wire                    full
);
  import gsm7_pkg::*;

  logic [7:0] septet_limit;
  logic [7:0] prior_octet, prior_octet_next;
  logic [7:0] septet_index, septet_index_next;
  logic       escape_pending, escape_pending_next;
  logic       limit_reached, limit_reached_next;

  logic [7:0]  prior_eff, idx_eff, idx1, idx2;
  logic        esc_eff, lr_eff, esc1, esc2;
  logic        a_valid, b_valid, comp_a, comp_b;
  logic [2:0]  sh;
  logic [3:0]  shamt;
  logic [15:0] joined;
  logic [6:0]  sa, sb;
  logic        accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !full;

  always_comb begin
    prior_eff = in_data.message_start ? 8'd0 : prior_octet;
    idx_eff   = in_data.message_start ? 8'd0 : septet_index;
    esc_eff   = in_data.message_start ? 1'b0 : escape_pending;
    lr_eff    = (in_data.message_start ? 1'b0 : limit_reached) || (idx_eff >= septet_limit);

    sh     = idx_eff[2:0];
    shamt  = 4'd8 - {1'b0, sh};
    joined = {in_data.packed_octet, prior_eff} >> shamt;
    sa     = joined[6:0];
    sb     = in_data.packed_octet[7:1];

    a_valid = !lr_eff;
    idx1    = idx_eff + 8'd1;
    comp_a  = idx1 >= septet_limit;
    esc1    = a_valid ? (!esc_eff && sa == ESC_SEPTET) : esc_eff;

    // A second septet sits in the top seven bits at shift six; drop a CR pad on the last octet
    b_valid = a_valid && sh == 3'd6 && !comp_a &&
              !(in_data.final_octet && sb == CR_SEPTET);
    idx2    = idx1 + 8'd1;
    comp_b  = idx2 >= septet_limit;
    esc2    = b_valid ? (!esc1 && sb == ESC_SEPTET) : esc1;

    prior_octet_next    = in_data.packed_octet;
    septet_index_next   = b_valid ? idx2 : (a_valid ? idx1 : idx_eff);
    escape_pending_next = esc2;
    limit_reached_next  = lr_eff || (a_valid && comp_a) || (b_valid && comp_b);

    push_data.sa      = sa;
    push_data.a_esc   = esc_eff;
    push_data.a_done  = comp_a;
    push_data.b_valid = b_valid;
    push_data.sb      = sb;
    push_data.b_esc   = esc1;
    push_data.b_done  = comp_b;
    push              = accept && a_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      septet_limit   <= 8'd0;
      prior_octet    <= 8'd0;
      septet_index   <= 8'd0;
      escape_pending <= 1'b0;
      limit_reached  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        septet_limit <= cfg_data;
      end
      if (accept) begin
        prior_octet    <= prior_octet_next;
        septet_index   <= septet_index_next;
        escape_pending <= escape_pending_next;
        limit_reached  <= limit_reached_next;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/gsm7_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module gsm7_queue (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  input  gsm7_pkg::septet_rec_t  push_data,
  input  wire                    pop,
  output gsm7_pkg::septet_rec_t  head,
  output logic                   full,
  output logic                   empty
);
  import gsm7_pkg::*;

  septet_rec_t         slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   fill;

  assign full  = fill == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign empty = fill == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/gsm7_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module gsm7_back (
  input  wire                    clk,
  input  wire                    rst,
  input  gsm7_pkg::septet_rec_t  head,
  input  wire                    empty,
  output logic                   pop,
  output logic                   out_valid,
  input  wire                    out_stall,
  output gsm7_pkg::out_word_t    out_data
);
  import gsm7_pkg::*;

  utf8_seq_t  ma, mb;
  logic [1:0] na, nb;
  logic [2:0] n_total, ptr, ptr_next, last_a;
  logic [7:0] seq [5];
  logic       load_ok, emit, at_end, tc;
  out_word_t  out_data_next;

  always_comb begin
    ma = map_septet(head.sa, head.a_esc);
    mb = map_septet(head.sb, head.b_esc);
    na = ma.n;
    nb = head.b_valid ? mb.n : 2'd0;
    n_total = {1'b0, na} + {1'b0, nb};
    last_a  = {1'b0, na} - 3'd1;

    case (na)
      2'd0: seq = '{mb.b0, mb.b1, mb.b2, 8'h00, 8'h00};
      2'd1: seq = '{ma.b0, mb.b0, mb.b1, mb.b2, 8'h00};
      2'd2: seq = '{ma.b0, ma.b1, mb.b0, mb.b1, mb.b2};
      default: seq = '{ma.b0, ma.b1, ma.b2, mb.b0, mb.b1};
    endcase

    load_ok = !out_valid || !out_stall;
    at_end  = ptr == n_total - 3'd1;
    tc      = (head.a_done && na != 2'd0 && ptr == last_a) ||
              (head.b_valid && head.b_done && nb != 2'd0 && at_end);
    emit    = !empty && load_ok && n_total != 3'd0;

    // drop a record that yields no bytes without touching the output
    pop      = !empty && (n_total == 3'd0 || (emit && at_end));
    ptr_next = (emit && !at_end) ? ptr + 3'd1 : 3'd0;
    if (!emit) begin
      ptr_next = ptr;
    end

    out_data_next.utf8_byte     = seq[ptr];
    out_data_next.run_last      = at_end;
    out_data_next.text_complete = tc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ptr       <= 3'd0;
    end else begin
      ptr <= ptr_next;
      if (load_ok) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= out_data_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/gsm7_unpack_to_utf8.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   handshake               word
// in        in_valid / in_stall     in_word_t: packed_octet, message_start, final_octet
// out       out_valid / out_stall   out_word_t: utf8_byte, run_last, text_complete
// cfg       cfg_valid / cfg_ready   cfg_data: septet_limit
//
// An octet is taken whenever the queue is not full; a four-entry septet queue decouples
// the input from the byte emitter, which sends one UTF-8 byte per cycle while out_stall
// is low; an octet yields 0 to 5 bytes, and a record with no bytes is popped unsent.
// Synchronous reset clears the unpack state, the septet limit and the queue.
// in_stall rises only when the queue is full; out_stall holds the output register.

module gsm7_unpack_to_utf8 (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  gsm7_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output gsm7_pkg::out_word_t  out_data,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [7:0]           cfg_data
);
  import gsm7_pkg::*;

  septet_rec_t push_data, head;
  logic        push, pop, full, empty;

  gsm7_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  gsm7_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  gsm7_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import gsm7_pkg::*;

  localparam logic [6:0] ESC_CODE  = 7'h1B;
  localparam logic [6:0] CR_CODE   = 7'h0D;
  localparam logic [6:0] EURO_CODE = 7'h65;
  localparam int SETTLE_CYCLES = 20;

  // Default alphabet as UTF-8, first byte in the low half, second byte zero if absent.
  localparam logic [15:0] GSM_UTF8 [0:127] = '{
    16'h0040, 16'ha3c2, 16'h0024, 16'ha5c2, 16'ha8c3, 16'ha9c3, 16'hb9c3, 16'hacc3,
    16'hb2c3, 16'h87c3, 16'h000A, 16'h98c3, 16'hb8c3, 16'h000D, 16'h85c3, 16'ha5c3,
    16'h94ce, 16'h005F, 16'ha6ce, 16'h93ce, 16'h9bce, 16'ha9ce, 16'ha0ce, 16'ha8ce,
    16'ha3ce, 16'h98ce, 16'h9ece, 16'h001B, 16'h86c3, 16'ha6c3, 16'hb2ce, 16'h89c3,
    16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'ha4c2, 16'h0025, 16'h0026, 16'h0027,
    16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
    16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
    16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
    16'ha1c2, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
    16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
    16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
    16'h0058, 16'h0059, 16'h005A, 16'h84c3, 16'h96c3, 16'h91c3, 16'h9cc3, 16'ha7c2,
    16'hbfc2, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
    16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
    16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
    16'h0078, 16'h0079, 16'h007A, 16'ha4c3, 16'hb6c3, 16'hb1c3, 16'hbcc3, 16'ha0c3
  };

  localparam logic [6:0] EXT_CODES [0:8] = '{
    7'h14, 7'h28, 7'h29, 7'h2F, 7'h3C, 7'h3D, 7'h3E, 7'h40, EURO_CODE
  };

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_data = '0;

  gsm7_unpack_to_utf8 dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // Unpacker state as the block should hold it
  logic [7:0] limit_reg  = '0;
  logic [7:0] last_octet = '0;
  logic [7:0] sept_count = '0;
  logic       esc_armed  = 1'b0;
  logic       text_done  = 1'b0;

  out_word_t  octet_run[$];
  out_word_t  utf8_expect[$];
  in_word_t   pending_octets[$];
  logic [6:0] septet_buf[$];
  int         fail_count = 0;

  logic word_taken = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;
  logic stall_now = 1'b0;
  int   stall_left = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

  function automatic void add_byte(logic [7:0] b);
    out_word_t w;
    w = '0;
    w.utf8_byte = b;
    if (octet_run.size() < 5) octet_run.push_back(w);
  endfunction

  function automatic void decode_septet(logic [6:0] s);
    logic [15:0] code;
    if (esc_armed) begin
      esc_armed = 1'b0;
      case (s)
        EURO_CODE: begin
          add_byte(8'hE2);
          add_byte(8'h82);
          add_byte(8'hAC);
        end
        7'h14: add_byte(8'h5E);
        7'h28: add_byte(8'h7B);
        7'h29: add_byte(8'h7D);
        7'h2F: add_byte(8'h5C);
        7'h3C: add_byte(8'h5B);
        7'h3D: add_byte(8'h7E);
        7'h3E: add_byte(8'h5D);
        7'h40: add_byte(8'h7C);
        default: ;
      endcase
    end else if (s == ESC_CODE) begin
      esc_armed = 1'b1;
    end else begin
      code = GSM_UTF8[s];
      add_byte(code[7:0]);
      if (code[15:8] != 8'h00) add_byte(code[15:8]);
    end
  endfunction

  function automatic void take_septet(logic [6:0] s);
    int        had;
    out_word_t tail;
    had = octet_run.size();
    decode_septet(s);
    sept_count = sept_count + 8'd1;
    if (sept_count >= limit_reg) begin
      text_done = 1'b1;
      if (octet_run.size() > had) begin
        tail = octet_run[octet_run.size() - 1];
        tail.text_complete = 1'b1;
        octet_run[octet_run.size() - 1] = tail;
      end
    end
  endfunction

  function automatic void predict_octet(in_word_t w);
    int        sh;
    int        joined;
    out_word_t tail;
    octet_run.delete();
    if (w.message_start) begin
      sept_count = '0;
      last_octet = '0;
      esc_armed  = 1'b0;
      text_done  = 1'b0;
    end
    if (sept_count >= limit_reg) text_done = 1'b1;
    if (!text_done) begin
      sh = int'(sept_count[2:0]);
      joined = (int'(w.packed_octet) << sh) | (int'(last_octet) >> (8 - sh));
      take_septet(joined[6:0]);
      // shift 6 carries a whole second septet; drop a CR pad on the final word
      if (sh == 6 && !text_done && !(w.final_octet && w.packed_octet[7:1] == CR_CODE))
        take_septet(w.packed_octet[7:1]);
    end
    last_octet = w.packed_octet;
    if (octet_run.size() > 0) begin
      tail = octet_run[octet_run.size() - 1];
      tail.run_last = 1'b1;
      octet_run[octet_run.size() - 1] = tail;
    end
    foreach (octet_run[i]) utf8_expect.push_back(octet_run[i]);
  endfunction

  function automatic void push_raw(logic [7:0] octet, logic start, logic last);
    in_word_t w;
    w.packed_octet  = octet;
    w.message_start = start;
    w.final_octet   = last;
    pending_octets.push_back(w);
  endfunction

  // Pack septet_buf LSB first into octets, flag the first and last word.
  function automatic int pack_message();
    int       n_oct;
    int       bitpos;
    int       j;
    int       b;
    in_word_t w;
    n_oct = (septet_buf.size() * 7 + 7) / 8;
    for (j = 0; j < n_oct; j++) begin
      w = '0;
      for (b = 0; b < 8; b++) begin
        bitpos = 8 * j + b;
        if (bitpos / 7 < septet_buf.size())
          w.packed_octet[b] = septet_buf[bitpos / 7][bitpos % 7];
      end
      w.message_start = (j == 0);
      w.final_octet   = (j == n_oct - 1);
      pending_octets.push_back(w);
    end
    septet_buf.delete();
    return n_oct;
  endfunction

  function automatic void fill_septets(int n);
    while (septet_buf.size() < n) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          septet_buf.push_back(ESC_CODE);
          septet_buf.push_back(EXT_CODES[$urandom_range(0, 8)]);
        end
        2: septet_buf.push_back(ESC_CODE);
        default: septet_buf.push_back(7'($urandom_range(0, 127)));
      endcase
    end
  endfunction

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_octets.size() != 0 || in_valid || utf8_expect.size() != 0);
    // words that yield no bytes may still sit in the septet queue
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    limit_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Accept and predict
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict_octet(in_data);
      word_taken = 1'b1;
    end
  end

  // Sender: bursts of words with random gaps between them
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !word_taken)) begin
      word_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_octets.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_octets.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: alternate free and stalled stretches, now and then a long free one
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      stall_now = !stall_now;
      if (stall_now)
        stall_left = $urandom_range(0, 4);
      else
        stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end
    out_stall <= stall_now;
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (utf8_expect.size() == 0) begin
        $error("unexpected word: utf8_byte %02h", out_data.utf8_byte);
        fail_count++;
      end else begin
        want = utf8_expect.pop_front();
        if (out_data.utf8_byte !== want.utf8_byte) begin
          $error("utf8_byte: expected %02h, got %02h", want.utf8_byte, out_data.utf8_byte);
          fail_count++;
        end
        if (out_data.run_last !== want.run_last) begin
          $error("run_last: expected %b, got %b", want.run_last, out_data.run_last);
          fail_count++;
        end
        if (out_data.text_complete !== want.text_complete) begin
          $error("text_complete: expected %b, got %b", want.text_complete,
                 out_data.text_complete);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int         phase_limits [0:8];
    int         lim;
    int         n;
    int         n_sept;
    int         phase_useful;
    int         phase_items;
    int         cap;
    phase_limits = '{1, 7, 8, 255, 0, 0, 3, 255, 16};
    phase_limits[5] = $urandom_range(2, 254);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // limit still zero after reset: nothing comes out
    push_raw(8'h41, 1'b1, 1'b1);
    wait_drained();

    // stop after three septets
    write_limit(8'd3);
    septet_buf = '{7'h48, 7'h45, 7'h4C, 7'h4C, 7'h4F, 7'h21, 7'h21};
    void'(pack_message());
    wait_drained();

    // raising the limit does not reopen the message
    write_limit(8'd255);
    push_raw(8'hC3, 1'b0, 1'b0);
    wait_drained();

    // euro, known and unknown escapes, extremes, escape as the last septet
    septet_buf = '{ESC_CODE, EURO_CODE, ESC_CODE, 7'h14, ESC_CODE, 7'h22, 7'h7F, ESC_CODE};
    void'(pack_message());
    // carry on past the final word without a new start
    push_raw(8'hFF, 1'b0, 1'b0);
    push_raw(8'h00, 1'b0, 1'b0);
    // seven septets and a CR pad
    septet_buf = '{7'h10, 7'h24, 7'h40, 7'h00, 7'h7F, 7'h1C, 7'h20, CR_CODE};
    void'(pack_message());
    wait_drained();

    foreach (phase_limits[p]) begin
      lim = phase_limits[p];
      write_limit(8'(lim));
      phase_useful = 0;
      phase_items  = 0;
      cap = lim * 7 / 8 + 1;
      while (phase_useful < 10 && phase_items < 20) begin
        if ($urandom_range(0, 6) == 0) begin
          n = $urandom_range(1, 3);
          repeat (n)
            push_raw(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                     $urandom_range(0, 3) == 0);
          phase_useful += n;
        end else begin
          if (lim >= 40)
            n_sept = ($urandom_range(0, 5) == 0) ? $urandom_range(32, 45) : $urandom_range(1, 24);
          else if ($urandom_range(0, 9) < 7)
            n_sept = (lim > 2) ? lim - 2 + $urandom_range(0, 4) : $urandom_range(1, 4);
          else
            n_sept = $urandom_range(1, 24);
          fill_septets(n_sept);
          if ($urandom_range(0, 7) == 0) septet_buf.push_back(ESC_CODE);
          if (septet_buf.size() % 8 == 7 && $urandom_range(0, 1) == 1)
            septet_buf.push_back(CR_CODE);
          n = pack_message();
          // words past the limit are dropped by the block; do not count them
          if (lim != 0) phase_useful += (n < cap) ? n : cap;
        end
        phase_items += n;
      end
      wait_drained();
    end

    if (utf8_expect.size() != 0) begin
      $error("%0d expected utf8 bytes never arrived", utf8_expect.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
